[hdl/udiv_pkg.sv]
package udiv_pkg;

	localparam int unsigned WordBits = 128;
	localparam int unsigned HalfBits = 64;
	localparam int unsigned StepCount = WordBits;

	typedef logic [WordBits-1:0] word_t;

	typedef struct packed {
		word_t num;
		word_t rem;
		word_t den;
		logic  zero;
	} udiv_work_t;

	typedef struct packed {
		logic [2*WordBits-1:0] data;
		logic                  zero;
	} udiv_result_t;

endpackage

[hdl/udiv_step.sv]
module udiv_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  udiv_pkg::udiv_work_t in_work,
	output logic                out_valid_s,
	output udiv_pkg::udiv_work_t out_work_s
);
	import udiv_pkg::*;

	logic [WordBits:0]   shifted;
	logic [WordBits+1:0] diff;
	logic                ge;
	udiv_work_t          next_work;

	always_comb begin
		shifted   = {in_work.rem, in_work.num[WordBits-1]};
		diff      = {1'b0, shifted} - {2'b00, in_work.den};
		ge        = ~diff[WordBits+1];
		next_work = in_work;
		next_work.num = {in_work.num[WordBits-2:0], ge};
		next_work.rem = ge ? diff[WordBits-1:0] : shifted[WordBits-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s <= 1'b0;
		end else if (en) begin
			out_valid_s <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_work_s <= next_work;
		end
	end

endmodule

[hdl/udiv_outq.sv]
module udiv_outq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  udiv_pkg::udiv_result_t push_data,
	input  logic                  pop,
	output logic                  not_full,
	output logic                  out_valid,
	output udiv_pkg::udiv_result_t out_data,
	output logic [1:0]            count
);
	import udiv_pkg::*;

	udiv_result_t mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push && pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign not_full  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_data  = mem_q[rd_ptr_q];
	assign count     = count_q;

endmodule

[hdl/unsigned_128_bit_divider_unit.sv]
// Channel   Dir  tdata (low bit up)                                   tuser
// s_axis    in   dividend_hi, dividend_lo, divisor_hi, divisor_lo     -
// m_axis    out  quotient_hi, quotient_lo, remainder_hi, remainder_lo zero_divisor
//
// One request per cycle while the output queue has room. Each request passes
// through 128 restoring-division stages, one quotient bit each, then a
// two-entry output queue.
// arst_n clears all valid bits and the queue; no data is lost on stall.
// The pipeline advances while the output queue has room; s_axis_tready follows it.
module unsigned_128_bit_divider_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [255:0] s_axis_tdata,  // dividend_hi, dividend_lo, divisor_hi, divisor_lo
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [255:0] m_axis_tdata,  // quotient_hi, quotient_lo, remainder_hi, remainder_lo
	output logic [0:0]   m_axis_tuser   // zero_divisor
);
	import udiv_pkg::*;

	logic         en;
	logic         not_full;
	logic         push;
	logic         pop;
	logic [1:0]   count;
	udiv_result_t push_data;
	udiv_result_t out_data;
	udiv_work_t   work_s  [StepCount+1];
	logic         valid_s [StepCount+1];
	word_t        in_num;
	word_t        in_den;
	word_t        quo;
	word_t        rmd;

	assign en            = not_full;
	assign s_axis_tready = en;

	assign in_num     = {s_axis_tdata[HalfBits-1:0], s_axis_tdata[2*HalfBits-1:HalfBits]};
	assign in_den     = {s_axis_tdata[3*HalfBits-1:2*HalfBits],
	                     s_axis_tdata[4*HalfBits-1:3*HalfBits]};
	assign work_s[0]  = {in_num, {WordBits{1'b0}}, in_den, (in_den == '0)};
	assign valid_s[0] = s_axis_tvalid;

	for (genvar k = 1; k <= StepCount; k++) begin : g_step
		udiv_step u_step (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.in_valid   (valid_s[k-1]),
			.in_work    (work_s[k-1]),
			.out_valid_s(valid_s[k]),
			.out_work_s (work_s[k])
		);
	end

	always_comb begin
		quo = work_s[StepCount].zero ? '0 : work_s[StepCount].num;
		rmd = work_s[StepCount].zero ? '0 : work_s[StepCount].rem;
		push_data.data = {rmd[HalfBits-1:0], rmd[WordBits-1:HalfBits],
		                  quo[HalfBits-1:0], quo[WordBits-1:HalfBits]};
		push_data.zero = work_s[StepCount].zero;
	end

	assign push = valid_s[StepCount] && en;
	assign pop  = m_axis_tvalid && m_axis_tready;

	udiv_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.not_full (not_full),
		.out_valid(m_axis_tvalid),
		.out_data (out_data),
		.count    (count)
	);

	assign m_axis_tdata    = out_data.data;
	assign m_axis_tuser[0] = out_data.zero;

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count != 2'd3)
		else $error("output queue over capacity");

	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
		else $error("zero divisor result not cleared");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(valid_s[StepCount]))
		else $error("last stage moved during stall");

endmodule
